// ----- sv/dscd_pkg.sv -----
// Shared constants and month-table function for the day serial to calendar date converter.
package dscd_pkg;

  localparam int unsigned SERIAL_BITS = 17;
  localparam int unsigned YEAR_W      = 12;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned DOY_W       = 9;   // day of year, holds up to 366

  localparam logic [YEAR_W-1:0] BASE_YEAR  = YEAR_W'(1900);
  localparam logic [DOY_W-1:0]  LEN_COMMON = DOY_W'(365);
  localparam logic [DOY_W-1:0]  LEN_LEAP   = DOY_W'(366);
  localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = MONTH_W'(11);

  typedef logic [DOY_W-1:0] doy_t;

  // Day of year (zero based) at which month idx+1 starts; idx is zero based.
  function automatic doy_t month_end(input logic leap, input logic [MONTH_W-1:0] idx);
    doy_t base;
    case (idx)
      4'd0:    base = DOY_W'(31);
      4'd1:    base = DOY_W'(59);
      4'd2:    base = DOY_W'(90);
      4'd3:    base = DOY_W'(120);
      4'd4:    base = DOY_W'(151);
      4'd5:    base = DOY_W'(181);
      4'd6:    base = DOY_W'(212);
      4'd7:    base = DOY_W'(243);
      4'd8:    base = DOY_W'(273);
      4'd9:    base = DOY_W'(304);
      4'd10:   base = DOY_W'(334);
      default: base = DOY_W'(365);
    endcase
    // February onward shifts by one in a leap year
    if (leap && idx != 4'd0) begin
      base = base + DOY_W'(1);
    end
    return base;
  endfunction

endpackage

// ----- sv/day_serial_to_calendar_date_top.sv -----
// Day serial to Gregorian date converter: year loop, month scan and output register.

// Converts a zero-based day count from 1 January 1900 into Gregorian year, month
// and day of month (full leap rule, 1900 is a common year). An accepted input runs
// the year loop and the month scan; its result then waits for a free output
// register and is loaded there, after which the next input is taken. The year loop
// removes each whole year past 1900 (up to 358 for a 17-bit serial); the month scan
// steps past each month before the result: a single compare/subtract unit removes
// one year per cycle, then the month table is scanned one entry per cycle. The
// input is stalled while a conversion is in progress; a finished result sits in an
// output register, so a new transaction may start while it waits. A result still
// waiting when the next conversion ends holds that one until the register frees up.
module day_serial_to_calendar_date_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dscd_pkg::SERIAL_BITS-1:0]    serial_days_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dscd_pkg::YEAR_W-1:0]         year_o,
  output logic [dscd_pkg::MONTH_W-1:0]        month_o,
  output logic [dscd_pkg::DAY_W-1:0]          day_of_month_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_YEAR  = 2'd1;
  localparam logic [1:0] ST_MONTH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [dscd_pkg::SERIAL_BITS-1:0] rest_q, rest_d;
  logic [dscd_pkg::YEAR_W-1:0] year_q, year_d;
  logic [1:0] mod4_q, mod4_d;       // year mod 4
  logic [6:0] mod100_q, mod100_d;   // year mod 100
  logic [1:0] cent4_q, cent4_d;     // century mod 4
  logic [dscd_pkg::MONTH_W-1:0] mon_q, mon_d;
  logic [dscd_pkg::DAY_W-1:0] day_q, day_d;

  logic out_valid_q, out_valid_d;
  logic [dscd_pkg::YEAR_W-1:0]  out_year_q;
  logic [dscd_pkg::MONTH_W-1:0] out_month_q;
  logic [dscd_pkg::DAY_W-1:0]   out_day_q;

  logic in_take, out_free, out_load, leap;
  dscd_pkg::doy_t year_len, mend, mprev, doy_diff;
  logic [dscd_pkg::SERIAL_BITS-1:0] len_ext;
  logic year_fits;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;

  assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) ||
                ((mod100_q == 7'd0) && (cent4_q == 2'd0));

  assign year_len  = leap ? dscd_pkg::LEN_LEAP : dscd_pkg::LEN_COMMON;
  assign len_ext   = dscd_pkg::SERIAL_BITS'(year_len);
  assign year_fits = (rest_q >= len_ext);

  assign mend     = dscd_pkg::month_end(leap, mon_q);
  assign mprev    = (mon_q == '0) ? '0 : dscd_pkg::month_end(leap, mon_q - 4'd1);
  assign doy_diff = rest_q[dscd_pkg::DOY_W-1:0] - mprev;

  always_comb begin
    state_d  = state_q;
    rest_d   = rest_q;
    year_d   = year_q;
    mod4_d   = mod4_q;
    mod100_d = mod100_q;
    cent4_d  = cent4_q;
    mon_d    = mon_q;
    day_d    = day_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          rest_d   = serial_days_i;
          year_d   = dscd_pkg::BASE_YEAR;
          mod4_d   = 2'd0;
          mod100_d = 7'd0;
          cent4_d  = 2'd3;   // 19 mod 4
          mon_d    = '0;
          state_d  = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (year_fits) begin
          rest_d = rest_q - len_ext;
          year_d = year_q + dscd_pkg::YEAR_W'(1);
          mod4_d = mod4_q + 2'd1;
          if (mod100_q == 7'd99) begin
            mod100_d = 7'd0;
            cent4_d  = cent4_q + 2'd1;
          end else begin
            mod100_d = mod100_q + 7'd1;
          end
        end else begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        // rest is below 366 here, so the low bits carry the day of year
        if ((mon_q < dscd_pkg::LAST_MONTH_IDX) &&
            (mend <= rest_q[dscd_pkg::DOY_W-1:0])) begin
          mon_d = mon_q + 4'd1;
        end else begin
          day_d   = doy_diff[dscd_pkg::DAY_W-1:0] + dscd_pkg::DAY_W'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    year_q   <= year_d;
    mod4_q   <= mod4_d;
    mod100_q <= mod100_d;
    cent4_q  <= cent4_d;
    mon_q    <= mon_d;
    day_q    <= day_d;
    if (out_load) begin
      out_year_q  <= year_q;
      out_month_q <= mon_q + dscd_pkg::MONTH_W'(1);
      out_day_q   <= day_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign year_o         = out_year_q;
  assign month_o        = out_month_q;
  assign day_of_month_o = out_day_q;

`ifndef ASSERT_OFF
  a_start_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == ST_YEAR))
    else $error("accepted transaction did not start the year loop");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1) && (month_o <= 4'd12))
    else $error("month out of range");

  a_month_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MONTH) |-> (mon_q <= dscd_pkg::LAST_MONTH_IDX) &&
      (rest_q < dscd_pkg::SERIAL_BITS'(dscd_pkg::LEN_LEAP)))
    else $error("month scan out of range");

  a_load_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !out_load) |=> out_valid_q)
    else $error("pending result dropped");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the day serial to calendar date converter: directed edges and random serials.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned MAX_SERIAL = (1 << dscd_pkg::SERIAL_BITS) - 1;

  typedef struct packed {
    logic [dscd_pkg::YEAR_W-1:0]  year;
    logic [dscd_pkg::MONTH_W-1:0] month;
    logic [dscd_pkg::DAY_W-1:0]   dom;
  } cal_date_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [dscd_pkg::SERIAL_BITS-1:0] serial_days_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [dscd_pkg::YEAR_W-1:0]      year_o;
  logic [dscd_pkg::MONTH_W-1:0]     month_o;
  logic [dscd_pkg::DAY_W-1:0]       day_of_month_o;

  cal_date_t   pending_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_wait = 0;
  bit          quiet = 1'b0;  // no idling on either side while set

  day_serial_to_calendar_date_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .serial_days_i  (serial_days_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned yr, int unsigned mon);
    case (mon)
      4, 6, 9, 11: return 30;
      2:           return is_leap(yr) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Serial of a given date, used to build stimulus around calendar edges
  function automatic int unsigned serial_of(int unsigned yr, int unsigned mon, int unsigned dom);
    int unsigned total;
    total = 0;
    for (int unsigned y = 1900; y < yr; y++) total += is_leap(y) ? 366 : 365;
    for (int unsigned m = 1; m < mon; m++) total += days_in_month(yr, m);
    return total + dom - 1;
  endfunction

  function automatic cal_date_t predict_date(logic [dscd_pkg::SERIAL_BITS-1:0] serial);
    int unsigned rest;
    int unsigned yr;
    int unsigned mon;
    cal_date_t   d;
    rest = 32'(serial);
    yr = 1900;
    while (rest >= (is_leap(yr) ? 366 : 365)) begin
      rest -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    while (mon < 12 && rest >= days_in_month(yr, mon)) begin
      rest -= days_in_month(yr, mon);
      mon++;
    end
    d.year  = dscd_pkg::YEAR_W'(yr);
    d.month = dscd_pkg::MONTH_W'(mon);
    d.dom   = dscd_pkg::DAY_W'(rest + 1);
    return d;
  endfunction

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Holds valid from the first offered cycle until the transaction is taken
  task automatic send_serial(int unsigned serial);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    serial_days_i <= dscd_pkg::SERIAL_BITS'(serial);
    do @(posedge clk_i); while (in_stall_o);
    pending_dates.push_back(predict_date(dscd_pkg::SERIAL_BITS'(serial)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result %0d-%0d-%0d with no conversion pending", $time,
                 year_o, month_o, day_of_month_o);
        mismatch_count++;
      end else begin
        cal_date_t want;
        want = pending_dates.pop_front();
        if (year_o !== want.year)
          report_mismatch("year", 32'(year_o), 32'(want.year));
        if (month_o !== want.month)
          report_mismatch("month", 32'(month_o), 32'(want.month));
        if (day_of_month_o !== want.dom)
          report_mismatch("day_of_month", 32'(day_of_month_o), 32'(want.dom));
      end
      rx_wait = draw_gap();
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (rx_wait != 0);
    if (rx_wait != 0) rx_wait = rx_wait - 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Field extremes, the 1900 and 2100 non-leap years, the 400-year rule, every month
  task automatic test_calendar_edges();
    send_serial(0);
    send_serial(MAX_SERIAL);
    send_serial(32'h15555);
    send_serial(32'h0aaaa);
    send_serial(serial_of(1900, 2, 28));
    send_serial(serial_of(1900, 3, 1));
    send_serial(serial_of(1904, 2, 29));
    send_serial(serial_of(1999, 12, 31));
    send_serial(serial_of(2000, 2, 29));
    send_serial(serial_of(2000, 12, 31));
    send_serial(serial_of(2100, 2, 28));
    send_serial(serial_of(2100, 3, 1));
    for (int unsigned m = 1; m <= 12; m++) send_serial(serial_of(2024, m, 1));
  endtask

  // Mostly uniform serials, some on month and year boundaries of random years, some small serials from 0 to 1500
  task automatic test_random_dates();
    int unsigned yr;
    int unsigned mon;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          yr  = $urandom_range(1900, 2257);
          mon = $urandom_range(1, 12);
          send_serial(serial_of(yr, mon, $urandom_range(0, 1) ? 1 : days_in_month(yr, mon)));
        end
        2:       send_serial($urandom_range(0, 1500));
        default: send_serial($urandom_range(0, MAX_SERIAL));
      endcase
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_calendar_edges();
    test_random_dates();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
